// File: design/u2j_pkg.sv
// Shared types, character codes and helpers for the UTF-8 to JSON escaper.
`default_nettype none

package u2j_pkg;

  // Default depth of the command queue between decoder and expander
  localparam int U2J_QUEUE_DEPTH = 4;

  // Command kinds handed from the decoder to the expander
  typedef enum logic [2:0] {
    CMD_CHAR = 3'd0,  // one character as is
    CMD_ESC  = 3'd1,  // backslash, then the character
    CMD_U16  = 3'd2,  // \uXXXX from val_hi
    CMD_PAIR = 3'd3,  // \uXXXX\uXXXX from val_hi, then val_lo
    CMD_ERR  = 3'd4,  // error marker
    CMD_DONE = 3'd5   // end-of-string marker, err tells truncation or error
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        err;
    logic [15:0] val_hi;
    logic [15:0] val_lo;
  } cmd_t;

  // ASCII codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // UTF-8 lead byte bounds
  localparam logic [7:0] LEAD_MIN   = 8'hC2;
  localparam logic [7:0] LEAD_LIMIT = 8'hF5;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;

  // Code point bounds
  localparam logic [20:0] CP_BMP_LOW_MAX  = 21'h00D7FF;
  localparam logic [20:0] CP_BMP_HIGH_MIN = 21'h00E000;
  localparam logic [20:0] CP_BMP_MAX      = 21'h00FFFF;
  localparam logic [20:0] CP_SUPP_MIN     = 21'h010000;
  localparam logic [20:0] CP_MAX          = 21'h10FFFF;

  // Surrogate prefixes (upper six bits of 0xD800 and 0xDC00)
  localparam logic [5:0] SUR_HI_PREFIX = 6'b110110;
  localparam logic [5:0] SUR_LO_PREFIX = 6'b110111;

  // Uppercase hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] w;
    w = {4'h0, v};
    hex_char = (v < 4'd10) ? (8'h30 + w) : (8'h37 + w);
  endfunction

endpackage

`default_nettype wire

// File: design/u2j_front.sv
// Decoder: accepts input bytes, validates UTF-8 and issues escape commands.
`default_nettype none

module u2j_front
  import u2j_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output      logic       s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,   // str_end
  input  wire logic       q_full,
  output      logic       q_push,
  output      cmd_t       q_cmd
);

  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [1:0]  seq_length, seq_length_next;
  logic [7:0]  lead_value, lead_value_next;
  logic [20:0] code_accum, code_accum_next;
  logic        error_latched, error_latched_next;

  logic        accept;
  logic        push;
  logic        bad;
  logic [7:0]  b;
  logic [20:0] accum_new;
  logic [20:0] s_off;
  logic [1:0]  pend_dec;
  cmd_t        cmd;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign q_push   = accept && push;
  assign q_cmd    = cmd;

  // Decode one byte into a command and the next sequence state
  always_comb begin
    bytes_pending_next = bytes_pending;
    seq_length_next    = seq_length;
    lead_value_next    = lead_value;
    code_accum_next    = code_accum;
    error_latched_next = error_latched;
    push               = 1'b0;
    bad                = 1'b0;
    cmd                = '0;
    accum_new          = {code_accum[14:0], b[5:0]};
    s_off              = accum_new - CP_SUPP_MIN;
    pend_dec           = bytes_pending - 2'd1;

    if (s_tlast) begin
      push               = 1'b1;
      cmd.kind           = CMD_DONE;
      cmd.err            = error_latched || (bytes_pending != 2'd0);
      bytes_pending_next = '0;
      seq_length_next    = '0;
      lead_value_next    = '0;
      code_accum_next    = '0;
      error_latched_next = 1'b0;
    end else if (error_latched) begin
      // drop the rest of a failed string
      push = 1'b0;
    end else if (bytes_pending == 2'd0) begin
      if (b < 8'h20) begin
        push       = 1'b1;
        cmd.kind   = CMD_U16;
        cmd.val_hi = {8'h00, b};
      end else if (b < 8'h80) begin
        push       = 1'b1;
        cmd.val_hi = {8'h00, b};
        if (b == CH_QUOTE || b == CH_APOS || b == CH_BSLASH || b == CH_SLASH) begin
          cmd.kind = CMD_ESC;
        end else begin
          cmd.kind = CMD_CHAR;
        end
      end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
        bad = 1'b1;
      end else begin
        // start a multi-byte sequence
        lead_value_next = b;
        if (b < LEAD_E0) begin
          seq_length_next    = 2'd1;
          bytes_pending_next = 2'd1;
          code_accum_next    = {16'h0000, b[4:0]};
        end else if (b < LEAD_F0) begin
          seq_length_next    = 2'd2;
          bytes_pending_next = 2'd2;
          code_accum_next    = {17'h00000, b[3:0]};
        end else begin
          seq_length_next    = 2'd3;
          bytes_pending_next = 2'd3;
          code_accum_next    = {18'h00000, b[2:0]};
        end
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end
      // second-byte bounds for overlong and out-of-range forms
      if (bytes_pending == seq_length) begin
        if (lead_value == LEAD_E0 && b < 8'hA0) bad = 1'b1;
        if (lead_value == LEAD_F0 && b < 8'h90) bad = 1'b1;
        if (lead_value == LEAD_F4 && b >= 8'h90) bad = 1'b1;
      end
      if (!bad) begin
        if (pend_dec != 2'd0) begin
          code_accum_next    = accum_new;
          bytes_pending_next = pend_dec;
        end else begin
          bytes_pending_next = '0;
          seq_length_next    = '0;
          lead_value_next    = '0;
          code_accum_next    = '0;
          if (accum_new <= CP_BMP_LOW_MAX ||
              (accum_new >= CP_BMP_HIGH_MIN && accum_new <= CP_BMP_MAX)) begin
            push       = 1'b1;
            cmd.kind   = CMD_U16;
            cmd.val_hi = accum_new[15:0];
          end else if (accum_new >= CP_SUPP_MIN && accum_new <= CP_MAX) begin
            push       = 1'b1;
            cmd.kind   = CMD_PAIR;
            cmd.val_hi = {SUR_HI_PREFIX, s_off[19:10]};
            cmd.val_lo = {SUR_LO_PREFIX, s_off[9:0]};
          end else begin
            bad = 1'b1;
          end
        end
      end
    end

    // Flag once, drop the partial sequence
    if (bad) begin
      bytes_pending_next = '0;
      seq_length_next    = '0;
      lead_value_next    = '0;
      code_accum_next    = '0;
      error_latched_next = 1'b1;
      push               = 1'b1;
      cmd                = '0;
      cmd.kind           = CMD_ERR;
      cmd.err            = 1'b1;
    end
  end

  // Advance decoder state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      seq_length    <= '0;
      lead_value    <= '0;
      code_accum    <= '0;
      error_latched <= 1'b0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      seq_length    <= seq_length_next;
      lead_value    <= lead_value_next;
      code_accum    <= code_accum_next;
      error_latched <= error_latched_next;
    end
  end

endmodule

`default_nettype wire

// File: design/u2j_queue.sv
// Small command queue between the decoder and the expander.
`default_nettype none

module u2j_queue
  import u2j_pkg::*;
#(
  parameter int Depth = U2J_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output      logic full,
  input  wire logic pop,
  output      cmd_t head_cmd,
  output      logic empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == FullCnt);
  assign empty    = (count == '0);
  assign head_cmd = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Track pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/u2j_back.sv
// Expander: turns queued commands into characters, one per cycle unless stalled.
`default_nettype none

module u2j_back
  import u2j_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       head_cmd,
  input  wire logic       q_empty,
  output      logic       q_pop,
  output      logic       m_tvalid,
  input  wire logic       m_tready,
  output      logic [7:0] m_tdata,   // [7:0] out_char
  output      logic       m_tlast,   // run_last
  output      logic [1:0] m_tuser    // [0] is_error, [1] is_done
);

  logic [3:0]  step;
  logic        load;
  logic        last;
  logic        sel_lo;
  logic [3:0]  sub;
  logic [15:0] word;
  logic [7:0]  u_char;
  logic [7:0]  ch;
  logic        err;
  logic        done;

  assign load  = !q_empty && (!m_tvalid || m_tready);
  assign q_pop = load && last;

  // Pick the current \uXXXX group and its position
  always_comb begin
    sel_lo = (head_cmd.kind == CMD_PAIR) && (step >= 4'd6);
    sub    = sel_lo ? (step - 4'd6) : step;
    word   = sel_lo ? head_cmd.val_lo : head_cmd.val_hi;
    unique case (sub)
      4'd0:    u_char = CH_BSLASH;
      4'd1:    u_char = CH_U;
      4'd2:    u_char = hex_char(word[15:12]);
      4'd3:    u_char = hex_char(word[11:8]);
      4'd4:    u_char = hex_char(word[7:4]);
      4'd5:    u_char = hex_char(word[3:0]);
      default: u_char = CH_NUL;
    endcase
  end

  // Select the character and flags for this step
  always_comb begin
    ch   = CH_NUL;
    err  = 1'b0;
    done = 1'b0;
    last = 1'b1;
    unique case (head_cmd.kind)
      CMD_CHAR: ch = head_cmd.val_hi[7:0];
      CMD_ESC: begin
        ch   = (step == 4'd0) ? CH_BSLASH : head_cmd.val_hi[7:0];
        last = (step == 4'd1);
      end
      CMD_U16: begin
        ch   = u_char;
        last = (step == 4'd5);
      end
      CMD_PAIR: begin
        ch   = u_char;
        last = (step == 4'd11);
      end
      CMD_ERR: err = 1'b1;
      CMD_DONE: begin
        err  = head_cmd.err;
        done = 1'b1;
      end
      default: ch = CH_NUL;
    endcase
  end

  // Hold or advance the output register and the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      step     <= last ? 4'd0 : step + 4'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load output payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= ch;
      m_tlast <= last;
      m_tuser <= {done, err};
    end
  end

endmodule

`default_nettype wire

// File: design/utf8_to_json_escaper_unit.sv
// Top level: UTF-8 to JSON escaper with decoder, command queue and expander.
// Path: the decoder writes each command into the queue, and the expander loads
// its first character into the output register, held there until m_tready.
// Throughput: one input byte per cycle while the queue has room; one output
// character per cycle while m_tready is high, up to 12 per byte, set by the single
// expander output port. Bytes that only open or extend a sequence queue nothing.
// Reset: synchronous rst clears decoder state, the queue and the output valid.
`default_nettype none

module utf8_to_json_escaper_unit
  import u2j_pkg::*;
#(
  parameter int QueueDepth = U2J_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output      logic       s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,   // str_end
  output      logic       m_tvalid,
  input  wire logic       m_tready,
  output      logic [7:0] m_tdata,   // [7:0] out_char
  output      logic       m_tlast,   // run_last
  output      logic [1:0] m_tuser    // [0] is_error, [1] is_done
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  u2j_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  u2j_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  u2j_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_cmd (head_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// File: test/tb.sv
// Testbench for utf8_to_json_escaper_unit: directed and random UTF-8 strings.

module tb
  import u2j_pkg::*;
;

  localparam int NDIR           = 36;
  localparam int RAND_ITEMS     = 270;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 30;
  localparam int CYCLE_LIMIT    = 1000000;

  // Second-byte bounds after the restricted lead bytes
  localparam logic [7:0] E0_SECOND_MIN   = 8'hA0;
  localparam logic [7:0] F0_SECOND_MIN   = 8'h90;
  localparam logic [7:0] F4_SECOND_LIMIT = 8'h90;

  // How a directed row is checked besides the predictor
  typedef enum logic [2:0] {
    CHK_PRED     = 3'd0,  // predictor only
    CHK_SILENT   = 3'd1,  // no character expected
    CHK_ERROR    = 3'd2,  // single error marker
    CHK_DONE_OK  = 3'd3,  // clean end of string
    CHK_DONE_BAD = 3'd4   // end of an invalid or truncated string
  } row_chk_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    row_chk_t   chk;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
    logic       done;
  } esc_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;  // [7:0] in_byte
  logic       s_tlast = 1'b0;   // str_end
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [7:0] out_char
  logic       m_tlast;          // run_last
  logic [1:0] m_tuser;          // [0] is_error, [1] is_done

  utf8_to_json_escaper_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Directed strings: specials, sequence extremes and every rejection rule except an F4 second byte above 8F
  dir_row_t dir_rows [NDIR] = '{
    '{8'h00, 1'b1, CHK_DONE_OK},
    '{8'h00, 1'b0, CHK_PRED},
    '{8'h1F, 1'b0, CHK_PRED},
    '{8'h22, 1'b0, CHK_PRED},
    '{8'h27, 1'b0, CHK_PRED},
    '{8'h5C, 1'b0, CHK_PRED},
    '{8'h2F, 1'b0, CHK_PRED},
    '{8'h7F, 1'b0, CHK_PRED},
    '{8'hC2, 1'b0, CHK_SILENT},
    '{8'h80, 1'b0, CHK_PRED},
    '{8'hF4, 1'b0, CHK_SILENT},
    '{8'h8F, 1'b0, CHK_SILENT},
    '{8'hBF, 1'b0, CHK_SILENT},
    '{8'hBF, 1'b0, CHK_PRED},
    '{8'hFF, 1'b1, CHK_DONE_OK},
    '{8'hED, 1'b0, CHK_SILENT},
    '{8'hA0, 1'b0, CHK_SILENT},
    '{8'h80, 1'b0, CHK_ERROR},
    '{8'hFF, 1'b0, CHK_SILENT},
    '{8'h00, 1'b1, CHK_DONE_BAD},
    '{8'hE0, 1'b0, CHK_SILENT},
    '{8'h9F, 1'b0, CHK_ERROR},
    '{8'h00, 1'b1, CHK_DONE_BAD},
    '{8'hF0, 1'b0, CHK_SILENT},
    '{8'h8F, 1'b0, CHK_ERROR},
    '{8'h00, 1'b1, CHK_DONE_BAD},
    '{8'h80, 1'b0, CHK_ERROR},
    '{8'h00, 1'b1, CHK_DONE_BAD},
    '{8'hFF, 1'b0, CHK_ERROR},
    '{8'h00, 1'b1, CHK_DONE_BAD},
    '{8'hC2, 1'b0, CHK_SILENT},
    '{8'h00, 1'b0, CHK_ERROR},
    '{8'h00, 1'b1, CHK_DONE_BAD},
    '{8'hE2, 1'b0, CHK_SILENT},
    '{8'h82, 1'b0, CHK_SILENT},
    '{8'h55, 1'b1, CHK_DONE_BAD}
  };

  // Escaper state mirrored by the testbench
  logic [1:0]  pend_cnt = '0;
  logic [1:0]  seq_len = '0;
  logic [7:0]  lead_byte = '0;
  logic [20:0] cp_accum = '0;
  logic        err_flag = 1'b0;
  esc_char_t   step_out [12];
  int          step_n;
  string       hex_digits = "0123456789ABCDEF";

  esc_char_t   expected_chars [$];
  logic [7:0]  str_bytes [$];

  int  fails = 0;
  int  cycle_cnt = 0;
  int  bytes_sent = 0;
  int  ends_sent = 0;
  int  chars_checked = 0;
  int  bad_strings = 0;
  bit  rx_hold = 1'b0;
  bit  tx_quiet = 1'b0;

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Cycle counter and run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
    $display("utf8_to_json_escaper_unit regression: fail");
    $finish;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_char(input logic [7:0] ch, input logic err, input logic done);
    step_out[step_n] = {ch, 1'b0, err, done};
    step_n++;
  endfunction

  // Emit \uXXXX with uppercase hex digits
  function automatic void put_u16(input logic [15:0] v);
    put_char(CH_BSLASH, 1'b0, 1'b0);
    put_char(CH_U, 1'b0, 1'b0);
    for (int i = 3; i >= 0; i--) put_char(hex_digits[v[4*i +: 4]], 1'b0, 1'b0);
  endfunction

  function automatic void clear_seq();
    pend_cnt  = '0;
    seq_len   = '0;
    lead_byte = '0;
    cp_accum  = '0;
  endfunction

  // Work out the characters one accepted transaction causes and queue them
  task automatic escape_byte(input logic [7:0] b, input logic fin);
    logic        bad;
    logic [20:0] cp;
    logic [20:0] ofs;
    bad = 1'b0;
    step_n = 0;
    if (fin) begin
      put_char(CH_NUL, err_flag || pend_cnt != 0, 1'b1);
      if (err_flag || pend_cnt != 0) bad_strings++;
      clear_seq();
      err_flag = 1'b0;
    end else if (!err_flag) begin
      if (pend_cnt == 0) begin
        if (b < 8'h20) begin
          put_u16({8'h00, b});
        end else if (b < 8'h80) begin
          if (b == CH_QUOTE || b == CH_APOS || b == CH_BSLASH || b == CH_SLASH)
            put_char(CH_BSLASH, 1'b0, 1'b0);
          put_char(b, 1'b0, 1'b0);
        end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
          bad = 1'b1;
        end else begin
          // open a sequence
          if (b < LEAD_E0) begin
            seq_len  = 2'd1;
            cp_accum = {16'h0, b[4:0]};
          end else if (b < LEAD_F0) begin
            seq_len  = 2'd2;
            cp_accum = {17'h0, b[3:0]};
          end else begin
            seq_len  = 2'd3;
            cp_accum = {18'h0, b[2:0]};
          end
          lead_byte = b;
          pend_cnt  = seq_len;
        end
      end else begin
        if (b[7:6] != 2'b10) bad = 1'b1;
        if (pend_cnt == seq_len) begin
          if (lead_byte == LEAD_E0 && b < E0_SECOND_MIN) bad = 1'b1;
          if (lead_byte == LEAD_F0 && b < F0_SECOND_MIN) bad = 1'b1;
          if (lead_byte == LEAD_F4 && b >= F4_SECOND_LIMIT) bad = 1'b1;
        end
        if (!bad) begin
          cp_accum = {cp_accum[14:0], b[5:0]};
          pend_cnt = pend_cnt - 2'd1;
          if (pend_cnt == 0) begin
            cp = cp_accum;
            clear_seq();
            if (cp <= CP_BMP_LOW_MAX || (cp >= CP_BMP_HIGH_MIN && cp <= CP_BMP_MAX)) begin
              put_u16(cp[15:0]);
            end else if (cp >= CP_SUPP_MIN && cp <= CP_MAX) begin
              ofs = cp - CP_SUPP_MIN;
              put_u16({SUR_HI_PREFIX, ofs[19:10]});
              put_u16({SUR_LO_PREFIX, ofs[9:0]});
            end else begin
              bad = 1'b1;
            end
          end
        end
      end
    end
    // drop the sequence and flag the string once
    if (bad) begin
      clear_seq();
      err_flag = 1'b1;
      step_n = 0;
      put_char(CH_NUL, 1'b1, 1'b0);
    end
    if (step_n > 0) step_out[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_chars.insert(expected_chars.size(), step_out[i]);
  endtask

  // Compare a directed row's typed expectation with the predicted characters
  task automatic check_typed(input logic [7:0] b, input row_chk_t chk);
    esc_char_t want;
    bit        ok;
    case (chk)
      CHK_ERROR:    want = {CH_NUL, 1'b1, 1'b1, 1'b0};
      CHK_DONE_OK:  want = {CH_NUL, 1'b1, 1'b0, 1'b1};
      CHK_DONE_BAD: want = {CH_NUL, 1'b1, 1'b1, 1'b1};
      default:      want = '0;
    endcase
    if (chk == CHK_SILENT) ok = (step_n == 0);
    else ok = (step_n == 1 && step_out[0] == want);
    if (!ok) begin
      fails++;
      $display("%0t: directed byte %h expected %0s (%h), actual %0d characters, first %h",
               $time, b, chk.name(), want, step_n, step_out[0]);
    end
  endtask

  // Offer one transaction, hold it until taken, then predict
  task automatic send_byte(input logic [7:0] b, input logic fin, input row_chk_t chk);
    int gap;
    gap = (tx_quiet || rx_hold) ? 0 : pick_gap();
    repeat (gap) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    escape_byte(b, fin);
    if (fin) ends_sent++;
    else bytes_sent++;
    if (chk != CHK_PRED) check_typed(b, chk);
  endtask

  // Add one byte at the end of the string under construction
  function automatic void append_byte(input logic [7:0] v);
    str_bytes.insert(str_bytes.size(), v);
  endfunction

  // Append the UTF-8 encoding of cp with nc continuation bytes
  function automatic void push_cp(input logic [20:0] cp, input int nc);
    case (nc)
      1: begin
        append_byte({3'b110, cp[10:6]});
      end
      2: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
      end
    endcase
    append_byte({2'b10, cp[5:0]});
  endfunction

  function automatic logic [20:0] pick_cp(input int nc);
    logic [20:0] cp;
    case (nc)
      1: cp = 21'($urandom_range(21'h80, 21'h7FF));
      2: begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        while (cp >= 21'hD800 && cp <= 21'hDFFF) cp = 21'($urandom_range(21'h800, 21'hFFFF));
      end
      default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
    endcase
    return cp;
  endfunction

  // Append a malformed fragment of one of several kinds
  function automatic void push_broken();
    int         nc;
    int         keep;
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: append_byte(8'($urandom_range(0, 255)));
      1: begin
        // truncated sequence: keep the lead and fewer continuations
        nc = $urandom_range(1, 3);
        push_cp(pick_cp(nc), nc);
        keep = $urandom_range(1, nc);
        repeat (nc + 1 - keep) void'(str_bytes.pop_back());
      end
      2: begin
        append_byte(8'($urandom_range(8'hC2, 8'hF4)));
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        append_byte(b);
      end
      3: begin
        append_byte(8'hED);
        append_byte(8'($urandom_range(8'hA0, 8'hBF)));
        append_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
      4: begin
        if ($urandom_range(0, 1) == 0) begin
          append_byte(LEAD_E0);
          append_byte(8'($urandom_range(8'h80, 8'h9F)));
        end else begin
          append_byte(LEAD_F0);
          append_byte(8'($urandom_range(8'h80, 8'h8F)));
          append_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        append_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
      default: begin
        append_byte(LEAD_F4);
        append_byte(8'($urandom_range(8'h90, 8'hBF)));
        append_byte(8'($urandom_range(8'h80, 8'hBF)));
        append_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
    endcase
  endfunction

  // Build one random string: mostly well-formed text, some broken fragments
  function automatic void build_string();
    int n_elem;
    int r;
    int nc;
    str_bytes.delete();
    n_elem = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 5);
    repeat (n_elem) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        case ($urandom_range(0, 6))
          0: append_byte(CH_QUOTE);
          1: append_byte(CH_APOS);
          2: append_byte(CH_BSLASH);
          3: append_byte(CH_SLASH);
          4: append_byte(CH_NUL);
          5: append_byte(8'h1F);
          default: append_byte(8'h7F);
        endcase
      end else if (r < 30) begin
        append_byte(8'($urandom_range(0, 127)));
      end else if (r < 82) begin
        nc = $urandom_range(1, 3);
        push_cp(pick_cp(nc), nc);
      end else begin
        push_broken();
      end
    end
  endfunction

  // Stimulus
  initial begin
    int rnd_items;
    int strings;
    rnd_items = 0;
    strings = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // walk the directed table
    for (int i = 0; i < NDIR; i++) send_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].chk);

    // random strings, each closed by an end-of-string transaction
    while (rnd_items < RAND_ITEMS) begin
      build_string();
      tx_quiet = ($urandom_range(0, 4) == 0);
      if (strings == 10) rx_hold = 1'b1;
      foreach (str_bytes[k]) begin
        send_byte(str_bytes[k], 1'b0, CHK_PRED);
        rnd_items++;
      end
      send_byte(8'($urandom_range(0, 255)), 1'b1, CHK_PRED);
      rnd_items++;
      strings++;
    end
    s_tvalid = 1'b0;

    // drain
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d strings (%0d flagged invalid or truncated),",
             bytes_sent, ends_sent, bad_strings);
    $display("checked %0d output characters, including a %0d-cycle output stall.",
             chars_checked, RX_HOLD_CYCLES);
    if (fails == 0) begin
      $display("utf8_to_json_escaper_unit regression: pass");
    end else begin
      $display("%0d mismatches", fails);
      $display("utf8_to_json_escaper_unit regression: fail");
    end
    $finish;
  end

  // Output side backpressure: random stalls, quiet stretches, one long hold
  initial begin
    int stall_left;
    int quiet_left;
    stall_left = 0;
    quiet_left = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        m_tready = 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
        rx_hold = 1'b0;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(50, 150);
        else if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %0s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Compare each output transaction with the oldest expected character
  always @(posedge clk) begin
    esc_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        fails++;
        $display("%0t: unexpected character, expected none, actual %h last %b user %b",
                 $time, m_tdata, m_tlast, m_tuser);
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        check_field("out_char", want.ch, m_tdata);
        check_field("run_last", {7'h0, want.last}, {7'h0, m_tlast});
        check_field("is_error", {7'h0, want.err}, {7'h0, m_tuser[0]});
        check_field("is_done", {7'h0, want.done}, {7'h0, m_tuser[1]});
      end
    end
  end

endmodule
